/* hdl/plcs_pkg.sv */
// shared types, widths and codes for the contrast stretch pipeline
package plcs_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int PIX_W      = PIXEL_BITS;
    localparam int PIX_MAX    = (1 << PIX_W) - 1;
    localparam int LEVEL_W    = 10;
    localparam int SPAN_W     = LEVEL_W;
    localparam int PROD_W     = SPAN_W + PIX_W;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = (PROD_W + DIV_STEP - 1) / DIV_STEP;
    localparam int QUO_W      = DIV_STAGES * DIV_STEP;
    localparam int RES_W      = QUO_W + 2;
    localparam int NUM_STAGES = DIV_STAGES + 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LEVEL_W;
    localparam int MODE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_LOW    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_HIGH   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_LOW    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_HIGH   = CFG_IDX_W'(4);

    localparam logic [MODE_W-1:0] MODE_GRAY = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_RGB  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_PASS = MODE_W'(2);

    typedef enum logic [1:0] {
        SEG_LOW,
        SEG_MID,
        SEG_HIGH
    } t_seg;

    typedef struct packed {
        logic [PIX_W-1:0] gray_or_red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] gray_or_red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
    } t_pix_out;

    typedef struct packed {
        logic [MODE_W-1:0]         pixel_mode;
        logic [PIX_W-1:0]          old_low;
        logic [PIX_W-1:0]          old_high;
        logic signed [LEVEL_W-1:0] new_low;
        logic signed [LEVEL_W-1:0] new_high;
    } t_cfg;

    // curve values derived from the registers, updated in the cycle after them
    typedef struct packed {
        logic [PIX_W-1:0]  den;
        logic [SPAN_W-1:0] span_mag;
        logic              span_neg;
    } t_curve;

    typedef struct packed {
        logic pass;
        logic zero;
    } t_lane_mode;

    typedef struct packed {
        logic [PIX_W-1:0] raw;
        t_seg             seg;
        logic             neg;
        logic [PIX_W-1:0] rem;
        logic [QUO_W-1:0] nq;
    } t_div_st;

endpackage

/* hdl/plcs_div_step.sv */
// one registered stage of the restoring divider, DIV_STEP (three) quotient bits per stage
module plcs_div_step (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [plcs_pkg::PIX_W-1:0]   i_den,
    input  plcs_pkg::t_div_st            i_st,
    output plcs_pkg::t_div_st            o_st
);

    plcs_pkg::t_div_st r_st;
    plcs_pkg::t_div_st n_st;

    always_comb begin
        logic [plcs_pkg::PIX_W:0]   tmp;
        logic [plcs_pkg::PIX_W-1:0] rem_v;
        logic [plcs_pkg::QUO_W-1:0] nq_v;
        logic                       qb;
        rem_v = i_st.rem;
        nq_v  = i_st.nq;
        for (int j = 0; j < plcs_pkg::DIV_STEP; j++) begin
            tmp = {rem_v, nq_v[plcs_pkg::QUO_W-1]};
            qb  = (tmp >= {1'b0, i_den});
            if (qb) begin
                rem_v = plcs_pkg::PIX_W'(tmp - {1'b0, i_den});
            end else begin
                rem_v = tmp[plcs_pkg::PIX_W-1:0];
            end
            // numerator bits leave at the top, quotient bits enter at the bottom
            nq_v = {nq_v[plcs_pkg::QUO_W-2:0], qb};
        end
        n_st     = i_st;
        n_st.rem = rem_v;
        n_st.nq  = nq_v;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

/* hdl/plcs_lane.sv */
// datapath of one colour channel: segment select, multiply, divide, saturate
module plcs_lane (
    input  logic                              i_clk,
    input  logic [plcs_pkg::NUM_STAGES-1:0]   i_load,
    input  plcs_pkg::t_cfg                    i_cfg,
    input  plcs_pkg::t_curve                  i_curve,
    input  plcs_pkg::t_lane_mode              i_mode,
    input  logic [plcs_pkg::PIX_W-1:0]        i_pix,
    output logic [plcs_pkg::PIX_W-1:0]        o_pix
);

    localparam logic signed [plcs_pkg::RES_W-1:0] LVL_MAX =
        plcs_pkg::RES_W'(plcs_pkg::PIX_MAX);

    // stage 1: segment and offset into the ramp
    logic [plcs_pkg::PIX_W-1:0] r_s1_raw;
    logic [plcs_pkg::PIX_W-1:0] r_s1_diff;
    plcs_pkg::t_seg             r_s1_seg;
    plcs_pkg::t_seg             n_s1_seg;

    always_comb begin
        if (i_pix <= i_cfg.old_low) begin
            n_s1_seg = plcs_pkg::SEG_LOW;
        end else if (i_pix <= i_cfg.old_high) begin
            n_s1_seg = plcs_pkg::SEG_MID;
        end else begin
            n_s1_seg = plcs_pkg::SEG_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_s1_raw  <= i_pix;
            r_s1_diff <= i_pix - i_cfg.old_low;
            r_s1_seg  <= n_s1_seg;
        end
    end

    // stage 2: magnitude of the ramp numerator
    plcs_pkg::t_div_st div_st [0:plcs_pkg::DIV_STAGES];
    plcs_pkg::t_div_st r_s2;

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_s2.raw <= r_s1_raw;
            r_s2.seg <= r_s1_seg;
            r_s2.neg <= i_curve.span_neg;
            r_s2.rem <= '0;
            r_s2.nq  <= plcs_pkg::QUO_W'(plcs_pkg::PROD_W'(i_curve.span_mag)
                                         * plcs_pkg::PROD_W'(r_s1_diff));
        end
    end

    assign div_st[0] = r_s2;

    for (genvar k = 0; k < plcs_pkg::DIV_STAGES; k++) begin : g_div
        plcs_div_step u_step (
            .i_clk  (i_clk),
            .i_load (i_load[2 + k]),
            .i_den  (i_curve.den),
            .i_st   (div_st[k]),
            .o_st   (div_st[k + 1])
        );
    end

    // last stage: signed quotient onto the low level in the middle segment, then saturate or apply the lane mode
    plcs_pkg::t_div_st                   fin;
    logic signed [plcs_pkg::RES_W-1:0]   q_s;
    logic signed [plcs_pkg::RES_W-1:0]   lvl;
    logic signed [plcs_pkg::RES_W-1:0]   nl_x;
    logic signed [plcs_pkg::RES_W-1:0]   nh_x;
    logic [plcs_pkg::PIX_W-1:0]          sat;
    logic [plcs_pkg::PIX_W-1:0]          n_out;
    logic [plcs_pkg::PIX_W-1:0]          r_out;

    assign fin  = div_st[plcs_pkg::DIV_STAGES];
    assign nl_x = {{(plcs_pkg::RES_W - plcs_pkg::LEVEL_W){i_cfg.new_low[plcs_pkg::LEVEL_W-1]}},
                   i_cfg.new_low};
    assign nh_x = {{(plcs_pkg::RES_W - plcs_pkg::LEVEL_W){i_cfg.new_high[plcs_pkg::LEVEL_W-1]}},
                   i_cfg.new_high};
    assign q_s  = fin.neg ? -$signed({2'b00, fin.nq}) : $signed({2'b00, fin.nq});

    always_comb begin
        unique case (fin.seg)
            plcs_pkg::SEG_LOW:  lvl = nl_x;
            plcs_pkg::SEG_MID:  lvl = nl_x + q_s;
            plcs_pkg::SEG_HIGH: lvl = nh_x;
            default:            lvl = nl_x;
        endcase
        if (lvl < 0) begin
            sat = '0;
        end else if (lvl > LVL_MAX) begin
            sat = plcs_pkg::PIX_W'(plcs_pkg::PIX_MAX);
        end else begin
            sat = lvl[plcs_pkg::PIX_W-1:0];
        end
        if (i_mode.pass) begin
            n_out = fin.raw;
        end else if (i_mode.zero) begin
            n_out = '0;
        end else begin
            n_out = sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[plcs_pkg::NUM_STAGES-1]) begin
            r_out <= n_out;
        end
    end

    assign o_pix = r_out;

endmodule

/* hdl/plcs_pipe_ctrl.sv */
// stage valid bits and per-stage load enables, bubbles collapse on a stall
module plcs_pipe_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [plcs_pkg::NUM_STAGES-1:0]   o_load
);

    logic [plcs_pkg::NUM_STAGES-1:0] r_vld;
    logic [plcs_pkg::NUM_STAGES-1:0] n_vld;
    logic [plcs_pkg::NUM_STAGES-1:0] up_v;
    logic [plcs_pkg::NUM_STAGES:0]   rdy;

    assign up_v = {r_vld[plcs_pkg::NUM_STAGES-2:0], i_in_valid};

    // a stage can take a request when empty or when its content moves on
    always_comb begin
        rdy[plcs_pkg::NUM_STAGES] = i_out_ready;
        for (int k = plcs_pkg::NUM_STAGES - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k + 1];
        end
        for (int k = 0; k < plcs_pkg::NUM_STAGES; k++) begin
            n_vld[k] = rdy[k] ? up_v[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_load      = rdy[plcs_pkg::NUM_STAGES-1:0] & up_v;
    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[plcs_pkg::NUM_STAGES-1];

`ifndef SYNTH
    logic in_acc;
    logic out_acc;
    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_vld[0])
        else $error("accepted request did not enter first stage");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_in_ready)
        else $error("empty first stage refused a request");

    a_count_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> ($countones(r_vld) == $past($countones(r_vld))
                     + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("request lost or duplicated in pipeline");
`endif

endmodule

/* hdl/piecewise_linear_contrast_stretch_core.sv */
// top level: register file, pipeline control and three channel lanes
// Maps each pixel through a three-segment gray-level curve set by old_low,
// old_high, new_low and new_high, in gray, RGB or pass-through mode. One
// pixel is accepted every clock while the pipeline is not stalled, and
// results leave in order. The pipeline runs through the segment and multiply
// stages, the six-stage restoring divider that resolves three quotient bits
// per stage, and the output register. Stalls at the output collapse bubbles
// before back-pressure reaches the input. Registers are written through the
// config port, which is always ready, and must only be changed while no
// pixel is in flight.
module piecewise_linear_contrast_stretch_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  plcs_pkg::t_pix_in                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output plcs_pkg::t_pix_out               o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [plcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [plcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    plcs_pkg::t_cfg   r_cfg;
    plcs_pkg::t_curve r_curve;
    plcs_pkg::t_curve n_curve;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_mode <= plcs_pkg::MODE_GRAY;
            r_cfg.old_low    <= '0;
            r_cfg.old_high   <= plcs_pkg::PIX_W'(plcs_pkg::PIX_MAX);
            r_cfg.new_low    <= '0;
            r_cfg.new_high   <= plcs_pkg::LEVEL_W'(plcs_pkg::PIX_MAX);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                plcs_pkg::CFG_PIXEL_MODE:
                    r_cfg.pixel_mode <= i_cfg_data[plcs_pkg::MODE_W-1:0];
                plcs_pkg::CFG_OLD_LOW:
                    r_cfg.old_low <= i_cfg_data[plcs_pkg::PIX_W-1:0];
                plcs_pkg::CFG_OLD_HIGH:
                    r_cfg.old_high <= i_cfg_data[plcs_pkg::PIX_W-1:0];
                plcs_pkg::CFG_NEW_LOW:
                    r_cfg.new_low <= i_cfg_data[plcs_pkg::LEVEL_W-1:0];
                plcs_pkg::CFG_NEW_HIGH:
                    r_cfg.new_high <= i_cfg_data[plcs_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // divisor and ramp height, only needed from the multiply stage on
    always_comb begin
        logic signed [plcs_pkg::LEVEL_W:0] span;
        span = {r_cfg.new_high[plcs_pkg::LEVEL_W-1], r_cfg.new_high}
             - {r_cfg.new_low[plcs_pkg::LEVEL_W-1], r_cfg.new_low};
        n_curve.den      = r_cfg.old_high - r_cfg.old_low;
        n_curve.span_neg = span[plcs_pkg::LEVEL_W];
        n_curve.span_mag = span[plcs_pkg::LEVEL_W] ? plcs_pkg::SPAN_W'(-span)
                                                   : plcs_pkg::SPAN_W'(span);
    end

    always_ff @(posedge i_clk) begin
        r_curve <= n_curve;
    end

    logic [plcs_pkg::NUM_STAGES-1:0] load;

    plcs_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_load      (load)
    );

    plcs_pkg::t_lane_mode mode_main;
    plcs_pkg::t_lane_mode mode_side;
    logic                 is_pass;

    // an unused mode code behaves as pass through
    assign is_pass = !(r_cfg.pixel_mode == plcs_pkg::MODE_GRAY
                    || r_cfg.pixel_mode == plcs_pkg::MODE_RGB);
    assign mode_main.pass = is_pass;
    assign mode_main.zero = 1'b0;
    assign mode_side.pass = is_pass;
    assign mode_side.zero = (r_cfg.pixel_mode == plcs_pkg::MODE_GRAY);

    plcs_lane u_lane_r (
        .i_clk   (i_clk),
        .i_load  (load),
        .i_cfg   (r_cfg),
        .i_curve (r_curve),
        .i_mode  (mode_main),
        .i_pix   (i_in_data.gray_or_red_in),
        .o_pix   (o_out_data.gray_or_red_out)
    );

    plcs_lane u_lane_g (
        .i_clk   (i_clk),
        .i_load  (load),
        .i_cfg   (r_cfg),
        .i_curve (r_curve),
        .i_mode  (mode_side),
        .i_pix   (i_in_data.green_in),
        .o_pix   (o_out_data.green_out)
    );

    plcs_lane u_lane_b (
        .i_clk   (i_clk),
        .i_load  (load),
        .i_cfg   (r_cfg),
        .i_curve (r_curve),
        .i_mode  (mode_side),
        .i_pix   (i_in_data.blue_in),
        .o_pix   (o_out_data.blue_out)
    );

endmodule
